>>> design/scld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scld_pkg;

    // Only line positions 0 to 15 are ever decoded; slots above that are never read.
    localparam int STORE_DEPTH = 16;
    localparam int STORE_IDX_W = 4;
    localparam int TDATA_W     = 104;
    localparam int RESULT_W    = 101;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_S     = "s";
    localparam logic [7:0] CHAR_Q     = "q";
    localparam logic [7:0] CHAR_Z     = "z";
    localparam logic [7:0] CHAR_A     = "a";
    localparam logic [7:0] CHAR_R     = "r";
    localparam logic [7:0] CHAR_P     = "p";
    localparam logic [7:0] CHAR_T     = "T";
    localparam logic [7:0] CHAR_ZERO  = "0";
    localparam logic [7:0] CHAR_ONE   = "1";

    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_STATE_QUERY  = 3'd1,
        CMD_CLOCK_READ   = 3'd2,
        CMD_CLOCK_SET    = 3'd3,
        CMD_ALARM_SET    = 3'd4,
        CMD_RADIO_OFF    = 3'd5,
        CMD_RADIO_ON     = 3'd6,
        CMD_INTERVAL_RUN = 3'd7
    } cmd_t;

    typedef logic [STORE_DEPTH-1:0][7:0] line_t;

    // Declared from the top bit down so the packed image matches the tdata layout.
    typedef struct packed {
        logic        manual_trigger;
        logic [16:0] shot_count;
        logic [15:0] interval_halfsec;
        logic [7:0]  second_field;
        logic [7:0]  minute_field;
        logic [7:0]  hour_field;
        logic [7:0]  weekday_field;
        logic [7:0]  day_field;
        logic [7:0]  month_field;
        logic [7:0]  year_field;
        cmd_t        command;
        logic [7:0]  echo_byte;
    } result_t;

    // Digit value with wrap, reduced to 8 bits.
    function automatic logic [7:0] digit8(input logic [7:0] ch);
        digit8 = ch - CHAR_ZERO;
    endfunction

    function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        two_digits = (digit8(hi) << 3) + (digit8(hi) << 1) + digit8(lo);
    endfunction

endpackage

`default_nettype wire

>>> design/scld_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scld_front #(
    parameter int LINE_DEPTH = 20
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire logic [7:0]     rx_byte,
    output scld_pkg::line_t     line,
    output logic [7:0]          byte_held
);
    import scld_pkg::*;

    localparam int SLOT_W = $clog2(LINE_DEPTH);

    line_t             line_reg;
    logic [7:0]        byte_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] cur_slot;

    // Wrap before the last slot is reached.
    assign cur_slot  = (slot_reg >= SLOT_W'(LINE_DEPTH - 1)) ? '0 : slot_reg;
    assign slot_next = (rx_byte == CHAR_CR) ? '0 : cur_slot + SLOT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= '0;
            slot_reg <= '0;
        end else if (load) begin
            slot_reg <= slot_next;
            if (cur_slot < SLOT_W'(STORE_DEPTH)) begin
                line_reg[cur_slot[STORE_IDX_W-1:0]] <= rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= rx_byte;
        end
    end

    assign line      = line_reg;
    assign byte_held = byte_reg;

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(LINE_DEPTH - 1))
        else $error("line pointer beyond last slot");

    a_cr_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load && rx_byte == CHAR_CR |=> slot_reg == '0)
        else $error("carriage return did not clear the line pointer");

endmodule

`default_nettype wire

>>> design/scld_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module scld_decode (
    input  wire scld_pkg::line_t  line,
    input  wire logic [7:0]       byte_held,
    output scld_pkg::result_t     result
);
    import scld_pkg::*;

    logic [15:0] d6, d7, d8, d9;
    logic [16:0] d11, d12, d13, d14, d15;

    // Wrap of (byte - '0') is the same in any result width.
    assign d6  = {8'h00, line[6]} - 16'(CHAR_ZERO);
    assign d7  = {8'h00, line[7]} - 16'(CHAR_ZERO);
    assign d8  = {8'h00, line[8]} - 16'(CHAR_ZERO);
    assign d9  = {8'h00, line[9]} - 16'(CHAR_ZERO);
    assign d11 = {9'h000, line[11]} - 17'(CHAR_ZERO);
    assign d12 = {9'h000, line[12]} - 17'(CHAR_ZERO);
    assign d13 = {9'h000, line[13]} - 17'(CHAR_ZERO);
    assign d14 = {9'h000, line[14]} - 17'(CHAR_ZERO);
    assign d15 = {9'h000, line[15]} - 17'(CHAR_ZERO);

    always_comb begin
        result           = '0;
        result.command   = CMD_NONE;
        result.echo_byte = byte_held;
        if (byte_held == CHAR_CR) begin
            unique case (line[0])
                CHAR_S: result.command = CMD_STATE_QUERY;
                CHAR_Q: result.command = CMD_CLOCK_READ;
                CHAR_Z: begin
                    result.command       = CMD_CLOCK_SET;
                    result.year_field    = two_digits(line[1], line[2]);
                    result.month_field   = two_digits(line[3], line[4]);
                    result.day_field     = two_digits(line[5], line[6]);
                    result.weekday_field = digit8(line[7]);
                    result.hour_field    = two_digits(line[9], line[10]);
                    result.minute_field  = two_digits(line[11], line[12]);
                    result.second_field  = two_digits(line[13], line[14]);
                end
                CHAR_A: begin
                    result.command      = CMD_ALARM_SET;
                    result.hour_field   = two_digits(line[1], line[2]);
                    result.minute_field = two_digits(line[3], line[4]);
                end
                CHAR_R: begin
                    if (line[1] == CHAR_ZERO) begin
                        result.command = CMD_RADIO_OFF;
                    end else if (line[1] == CHAR_ONE) begin
                        result.command = CMD_RADIO_ON;
                    end
                end
                CHAR_P: begin
                    result.command = CMD_INTERVAL_RUN;
                    if (line[1] == CHAR_T) begin
                        result.manual_trigger = 1'b1;
                    end else begin
                        result.hour_field   = two_digits(line[1], line[2]);
                        result.minute_field = two_digits(line[3], line[4]);
                    end
                    result.interval_halfsec = d6 * 16'd1000 + d7 * 16'd100
                                            + d8 * 16'd10 + d9;
                    result.shot_count = d11 * 17'd10000 + d12 * 17'd1000
                                      + d13 * 17'd100 + d14 * 17'd10 + d15;
                end
                default: result.command = CMD_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/serial_command_line_decoder_unit.sv
// A byte is held in the input register; its decode is registered to m_tdata.
// Throughput: one byte per cycle; the input register and result register form a
//   two-stage pipeline that stalls only when m_tready is low with both stages full.
// Reset (aresetn low, synchronous): line buffer cleared to zero, line pointer to slot 0,
//   both pipeline stages emptied.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_decoder_unit #(
    parameter int LINE_DEPTH = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [7:0] echo_byte, [10:8] command, [18:11] year_field, [26:19] month_field,
    // [34:27] day_field, [42:35] weekday_field, [50:43] hour_field,
    // [58:51] minute_field, [66:59] second_field, [82:67] interval_halfsec,
    // [99:83] shot_count, [100] manual_trigger, [103:101] zero
    output logic [scld_pkg::TDATA_W-1:0] m_tdata
);
    import scld_pkg::*;

    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t decoded;
    line_t   line;
    logic [7:0] byte_held;
    logic    load;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    scld_front #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .rx_byte   (s_tdata),
        .line      (line),
        .byte_held (byte_held)
    );

    scld_decode u_decode (
        .line      (line),
        .byte_held (byte_held),
        .result    (decoded)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until the downstream transfer completes.
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg};

    a_cmd_needs_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.command != CMD_NONE |-> result_reg.echo_byte == CHAR_CR)
        else $error("command decoded on a byte other than carriage return");

    a_manual_program: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.manual_trigger |->
            result_reg.command == CMD_INTERVAL_RUN && result_reg.hour_field == '0
            && result_reg.minute_field == '0)
        else $error("manual trigger outside a manual program command");

    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.command == CMD_NONE |->
            result_reg.year_field == '0 && result_reg.hour_field == '0
            && result_reg.shot_count == '0 && result_reg.interval_halfsec == '0)
        else $error("decoded fields set without a command");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_held))
        else $error("held input byte overwritten before it was decoded");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import scld_pkg::*;

    localparam int LINE_DEPTH   = 20;
    localparam int TOTAL_ITEMS  = 1700;
    localparam int CALM_TAIL    = 300;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        cmd_t       cmd;
    } stim_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;

    // Typed rows carry an echo with the given command and all fields zero.
    stim_t directed_tab [25] = '{
        '{CHAR_S,    1'b1, CMD_NONE},      '{CHAR_CR,   1'b1, CMD_STATE_QUERY},
        '{CHAR_Q,    1'b1, CMD_NONE},      '{CHAR_CR,   1'b1, CMD_CLOCK_READ},
        '{CHAR_R,    1'b1, CMD_NONE},      '{CHAR_ZERO, 1'b1, CMD_NONE},
        '{CHAR_CR,   1'b1, CMD_RADIO_OFF},
        '{CHAR_R,    1'b1, CMD_NONE},      '{CHAR_ONE,  1'b1, CMD_NONE},
        '{CHAR_CR,   1'b1, CMD_RADIO_ON},
        '{CHAR_R,    1'b1, CMD_NONE},      '{8'h39,     1'b1, CMD_NONE},
        '{CHAR_CR,   1'b1, CMD_NONE},
        '{8'hFF,     1'b1, CMD_NONE},      '{8'h00,     1'b1, CMD_NONE},
        '{CHAR_CR,   1'b1, CMD_NONE},
        '{CHAR_A,    1'b1, CMD_NONE},      '{8'h32,     1'b1, CMD_NONE},
        '{8'h33,     1'b1, CMD_NONE},      '{8'h35,     1'b1, CMD_NONE},
        '{8'h39,     1'b1, CMD_NONE},      '{CHAR_CR,   1'b0, CMD_NONE},
        '{CHAR_P,    1'b1, CMD_NONE},      '{CHAR_T,    1'b1, CMD_NONE},
        '{CHAR_CR,   1'b0, CMD_NONE}
    };

    stim_t       stim_q[$];
    result_t     pending_q[$];
    logic [7:0]  line_img [LINE_DEPTH];
    int unsigned wr_slot;
    int unsigned bytes_in;
    int unsigned mismatches;
    int unsigned idle_cycles;

    serial_command_line_decoder_unit #(
        .LINE_DEPTH(LINE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] digit_val(input int unsigned pos);
        return {24'd0, line_img[pos % LINE_DEPTH]} - 32'h30;
    endfunction

    function automatic logic [31:0] pair_val(input int unsigned pos);
        return digit_val(pos) * 10 + digit_val(pos + 1);
    endfunction

    // Store the byte, then decode the whole line on a carriage return.
    function automatic result_t decode_byte(input logic [7:0] ch);
        result_t r;
        r = '0;
        if (wr_slot >= LINE_DEPTH - 1)
            wr_slot = 0;
        line_img[wr_slot] = ch;
        wr_slot++;
        r.echo_byte = ch;
        if (ch == CHAR_CR) begin
            case (line_img[0])
                CHAR_S: r.command = CMD_STATE_QUERY;
                CHAR_Q: r.command = CMD_CLOCK_READ;
                CHAR_Z: begin
                    r.command       = CMD_CLOCK_SET;
                    r.year_field    = 8'(pair_val(1));
                    r.month_field   = 8'(pair_val(3));
                    r.day_field     = 8'(pair_val(5));
                    r.weekday_field = 8'(digit_val(7));
                    r.hour_field    = 8'(pair_val(9));
                    r.minute_field  = 8'(pair_val(11));
                    r.second_field  = 8'(pair_val(13));
                end
                CHAR_A: begin
                    r.command      = CMD_ALARM_SET;
                    r.hour_field   = 8'(pair_val(1));
                    r.minute_field = 8'(pair_val(3));
                end
                CHAR_R: begin
                    if (line_img[1] == CHAR_ZERO)
                        r.command = CMD_RADIO_OFF;
                    else if (line_img[1] == CHAR_ONE)
                        r.command = CMD_RADIO_ON;
                end
                CHAR_P: begin
                    r.command = CMD_INTERVAL_RUN;
                    if (line_img[1] == CHAR_T) begin
                        r.manual_trigger = 1'b1;
                    end else begin
                        r.hour_field   = 8'(pair_val(1));
                        r.minute_field = 8'(pair_val(3));
                    end
                    r.interval_halfsec = 16'(digit_val(6) * 1000 + digit_val(7) * 100 +
                                             digit_val(8) * 10 + digit_val(9));
                    r.shot_count = 17'(digit_val(11) * 10000 + digit_val(12) * 1000 +
                                       digit_val(13) * 100 + digit_val(14) * 10 +
                                       digit_val(15));
                end
                default: ;
            endcase
            wr_slot = 0;
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_digit();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic void add_char(input logic [7:0] ch);
        stim_q.push_back('{ch, 1'b0, CMD_NONE});
    endfunction

    // Mostly well-formed command lines, some cut short, some noise and overlong lines.
    task automatic build_random_lines();
        logic [7:0] line[$];
        int unsigned keep;
        while (stim_q.size() < TOTAL_ITEMS) begin
            line = {};
            case ($urandom_range(0, 9))
                0: line.push_back($urandom_range(0, 1) ? CHAR_S : CHAR_Q);
                1, 2: begin
                    line.push_back(CHAR_Z);
                    repeat (14) line.push_back(rand_digit());
                end
                3: begin
                    line.push_back(CHAR_A);
                    repeat (4) line.push_back(rand_digit());
                end
                4: begin
                    line.push_back(CHAR_R);
                    case ($urandom_range(0, 2))
                        0: line.push_back(CHAR_ZERO);
                        1: line.push_back(CHAR_ONE);
                        default: line.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                5, 6: begin
                    line.push_back(CHAR_P);
                    if ($urandom_range(0, 2) == 0) begin
                        line.push_back(CHAR_T);
                        repeat (3) line.push_back(rand_digit());
                    end else begin
                        repeat (4) line.push_back(rand_digit());
                    end
                    line.push_back(8'h20);
                    repeat (4) line.push_back(rand_digit());
                    line.push_back(8'h20);
                    repeat (5) line.push_back(rand_digit());
                end
                7: repeat ($urandom_range(0, 45)) line.push_back(8'($urandom_range(0, 255)));
                8: begin
                    // overlong line: the pointer wraps and overwrites the lead character
                    case ($urandom_range(0, 2))
                        0: line.push_back(CHAR_Z);
                        1: line.push_back(CHAR_P);
                        default: line.push_back(CHAR_A);
                    endcase
                    repeat ($urandom_range(19, 40)) line.push_back(rand_digit());
                end
                default: ;
            endcase
            if (line.size() > 0 && $urandom_range(0, 7) == 0) begin
                keep = $urandom_range(0, line.size() - 1);
                while (line.size() > keep) void'(line.pop_back());
            end
            foreach (line[i]) add_char(line[i]);
            add_char(CHAR_CR);
        end
    endtask

    task automatic send_byte(input logic [7:0] ch);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void report_result(input result_t want, input result_t got);
        $write("  expected: echo=%h cmd=%0d yr=%h mo=%h dy=%h wd=%h",
               want.echo_byte, want.command, want.year_field, want.month_field,
               want.day_field, want.weekday_field);
        $display(" hr=%h mi=%h se=%h iv=%h sh=%h man=%b",
                 want.hour_field, want.minute_field, want.second_field,
                 want.interval_halfsec, want.shot_count, want.manual_trigger);
        $write("  actual:   echo=%h cmd=%0d yr=%h mo=%h dy=%h wd=%h",
               got.echo_byte, got.command, got.year_field, got.month_field,
               got.day_field, got.weekday_field);
        $display(" hr=%h mi=%h se=%h iv=%h sh=%h man=%b",
                 got.hour_field, got.minute_field, got.second_field,
                 got.interval_halfsec, got.shot_count, got.manual_trigger);
    endfunction

    function automatic bit fields_differ(input result_t want, input result_t got);
        return got.echo_byte !== want.echo_byte || got.command !== want.command ||
               got.year_field !== want.year_field || got.month_field !== want.month_field ||
               got.day_field !== want.day_field || got.weekday_field !== want.weekday_field ||
               got.hour_field !== want.hour_field || got.minute_field !== want.minute_field ||
               got.second_field !== want.second_field ||
               got.interval_halfsec !== want.interval_halfsec ||
               got.shot_count !== want.shot_count ||
               got.manual_trigger !== want.manual_trigger;
    endfunction

    // Predict on each input transfer, check each output transfer against the oldest one.
    always @(posedge aclk) begin : scoreboard
        result_t want;
        result_t got;
        stim_t   item;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected output transfer: tdata=%h", m_tdata);
                end else begin
                    want = pending_q.pop_front();
                    if (fields_differ(want, got) || m_tdata[TDATA_W-1:RESULT_W] !== '0) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("output mismatch, tdata=%h", m_tdata);
                            report_result(want, got);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item = stim_q[bytes_in];
                want = decode_byte(s_tdata);
                if (item.typed) begin
                    want           = '0;
                    want.echo_byte = item.ch;
                    want.command   = item.cmd;
                end
                pending_q.push_back(want);
                bytes_in++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[serial_command_line_decoder_unit] ERROR");
                $finish;
            end
        end
    end

    // Receiver pacing: random stall bursts, one long hold-off to back up the pipeline.
    initial begin : sink_pace
        int unsigned n;
        bit          held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_off && bytes_in >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (bytes_in + CALM_TAIL < TOTAL_ITEMS && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : main
        int unsigned idx;
        int unsigned n;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        bytes_in    = 0;
        mismatches  = 0;
        idle_cycles = 0;
        wr_slot     = 0;
        foreach (line_img[i]) line_img[i] = '0;
        foreach (directed_tab[i]) stim_q.push_back(directed_tab[i]);
        build_random_lines();

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (idx = 0; idx < stim_q.size(); idx++) begin
            if (idx + CALM_TAIL < stim_q.size() && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                s_tvalid <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            send_byte(stim_q[idx].ch);
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("[serial_command_line_decoder_unit] OK");
        else
            $display("[serial_command_line_decoder_unit] ERROR");
        $finish;
    end

endmodule
